// ----- rtl/complex_descending_tagged_sort_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the complex descending tagged sort
// Shorthand for clocked, reset-qualified checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_DESCENDING_TAGGED_SORT_MACROS_SVH
`define COMPLEX_DESCENDING_TAGGED_SORT_MACROS_SVH

// cons must hold in the cycle after ante
`define CDTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("cdts check failed: next-cycle rule");

// sig must not change in the cycle after cond
`define CDTS_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |=> $stable(sig)) else $error("cdts check failed: hold rule");

`endif

// ----- rtl/cdts_pkg.sv -----
// ----------------------------------------------------------------------------
// cdts_pkg
// Types and constants shared by the complex descending tagged sort.
// ----------------------------------------------------------------------------
package cdts_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned TAG_W  = 10;
    localparam int unsigned KEY_W  = 64;

    // input item
    typedef struct packed {
        logic signed [WORD_W-1:0] real_part;
        logic signed [WORD_W-1:0] imag_part;
        logic [TAG_W-1:0]         tag;
        logic                     last_in;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [WORD_W-1:0] sorted_real;
        logic signed [WORD_W-1:0] sorted_imag;
        logic [TAG_W-1:0]         sorted_tag;
        logic                     last_out;
    } t_out_item;

    // one stored entry: squared magnitude, the value, its tag and an
    // emitted flag (cleared when the entry is loaded)
    typedef struct packed {
        logic [KEY_W-1:0]         sq_mag;
        logic signed [WORD_W-1:0] re;
        logic signed [WORD_W-1:0] im;
        logic [TAG_W-1:0]         tag;
        logic                     done;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_RE,
        S_SQ_IM,
        S_WRITE,
        S_SCAN,
        S_EMIT
    } t_state;

    // squared magnitude unit control
    typedef struct packed {
        logic en;
        logic sel_im;
    } t_sq_ctrl;

    // scan / compare unit control
    typedef struct packed {
        logic start;
        logic cmp_en;
        logic cand_ok;
        logic any_imag;
    } t_scan_ctrl;

endpackage

// ----- rtl/cdts_stream_if.sv -----
// ----------------------------------------------------------------------------
// cdts_stream_if
// Valid/ready stream channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
interface cdts_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/cdts_ram.sv -----
// ----------------------------------------------------------------------------
// cdts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cdts_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cdts_sqmag.sv -----
// ----------------------------------------------------------------------------
// cdts_sqmag
// Squared magnitude with one shared 32x32 multiplier, real part then imaginary part.
// ----------------------------------------------------------------------------
module cdts_sqmag (
    input  logic                                 i_clk,
    input  cdts_pkg::t_sq_ctrl                   i_ctrl,
    input  logic signed [cdts_pkg::WORD_W-1:0]   i_re,
    input  logic signed [cdts_pkg::WORD_W-1:0]   i_im,
    output logic [cdts_pkg::KEY_W-1:0]           o_sq_mag
);
    import cdts_pkg::*;

    logic [WORD_W-1:0] re_u;
    logic [WORD_W-1:0] im_u;
    logic [WORD_W-1:0] abs_re;
    logic [WORD_W-1:0] abs_im;
    logic [WORD_W-1:0] op;
    logic [KEY_W-1:0]  n_prod;
    logic [KEY_W-1:0]  r_prod;
    logic [KEY_W-1:0]  r_acc;

    // magnitudes; -2^31 maps to 2^31, which fits unsigned
    always_comb begin
        re_u   = i_re;
        im_u   = i_im;
        abs_re = re_u[WORD_W-1] ? (~re_u + WORD_W'(1)) : re_u;
        abs_im = im_u[WORD_W-1] ? (~im_u + WORD_W'(1)) : im_u;
        op     = i_ctrl.sel_im ? abs_im : abs_re;
        n_prod = KEY_W'(op) * KEY_W'(op);
    end

    // the real part is squared first, then the imaginary part
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_prod <= n_prod;
            r_acc  <= r_prod;
        end
    end

    // sum is at most 2^63, no overflow
    assign o_sq_mag = r_acc + r_prod;

endmodule

// ----- rtl/cdts_scan.sv -----
// ----------------------------------------------------------------------------
// cdts_scan
// Shared key compare unit: tracks the best remaining entry over one scan.
// ----------------------------------------------------------------------------
module cdts_scan #(
    parameter int unsigned AW = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdts_pkg::t_scan_ctrl i_ctrl,
    input  cdts_pkg::t_entry    i_entry,
    input  logic [AW-1:0]       i_addr,
    output cdts_pkg::t_entry    o_best,
    output logic [AW-1:0]       o_best_addr
);
    import cdts_pkg::*;

    logic [KEY_W-1:0] key;
    logic             take;
    logic             r_have_best;
    logic [KEY_W-1:0] r_best_key;
    t_entry           r_best;
    logic [AW-1:0]    r_best_addr;

    // key: squared magnitude, or the real part with its sign bit flipped so
    // that an unsigned compare orders signed values
    always_comb begin
        key = i_ctrl.any_imag ? i_entry.sq_mag
                              : {{(KEY_W-WORD_W){1'b0}}, ~i_entry.re[WORD_W-1],
                                 i_entry.re[WORD_W-2:0]};
        // strict compare keeps the earliest of equal keys
        take = i_ctrl.cmp_en && i_ctrl.cand_ok && (!r_have_best || (key > r_best_key));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
        end else if (i_ctrl.start) begin
            r_have_best <= 1'b0;
        end else if (take) begin
            r_have_best <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_key  <= key;
            r_best      <= i_entry;
            r_best_addr <= i_addr;
        end
    end

    assign o_best      = r_best;
    assign o_best_addr = r_best_addr;

endmodule

// ----- rtl/complex_descending_tagged_sort.sv -----
// Loading: each item goes through transfer, real and imaginary multiplier steps
// and store write before the next item is taken. Sorting: each result takes
// one scan of the n stored items (one entry per cycle through the single RAM read
// port and the shared key comparator), so a set drains with one scan per result.
// Reset: synchronous, active low; clears sequencer, counts and flags only.
// Stores are not cleared, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// complex_descending_tagged_sort
// Loads tagged complex values and emits them in descending key order.
// ----------------------------------------------------------------------------
module complex_descending_tagged_sort #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cdts_stream_if.sink          i_in,
    cdts_stream_if.source        o_out
);
    import cdts_pkg::*;

    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CW-1:0]         r_count;
    logic                  r_any_imag;
    t_in_item              r_in;
    logic [CW-1:0]         r_rd_addr;
    logic                  r_pend;
    logic [AW-1:0]         r_pend_addr;
    logic [CW-1:0]         r_emit_cnt;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  in_fire;
    logic                  not_full;
    logic                  issue;
    logic                  scan_done;
    logic                  scan_start;
    logic                  out_free;
    logic                  emit;
    logic                  last_emit;
    logic                  load_we;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    t_entry                ram_wdata;
    t_entry                ram_rdata;
    t_entry                best;
    logic [AW-1:0]         best_addr;
    logic [KEY_W-1:0]      sq_mag;
    t_sq_ctrl              sq_ctrl;
    t_scan_ctrl            scan_ctrl;

    assign in_fire   = i_in.valid && i_in.ready;
    assign not_full  = (r_count < CW'(MAX_ITEMS));
    assign scan_done = (r_rd_addr == r_count) && !r_pend;
    assign out_free  = !r_out_valid || o_out.ready;
    assign last_emit = (r_emit_cnt == (r_count - CW'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (not_full) begin
                        n_state = S_SQ_RE;
                    end else if (i_in.data.last_in) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SQ_RE: n_state = S_SQ_IM;
            S_SQ_IM: n_state = S_WRITE;
            S_WRITE: n_state = r_in.last_in ? S_SCAN : S_IDLE;
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = last_emit ? S_IDLE : S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_in.ready         = (r_state == S_IDLE);
        sq_ctrl.en         = (r_state == S_SQ_RE) || (r_state == S_SQ_IM);
        sq_ctrl.sel_im     = (r_state == S_SQ_IM);
        load_we            = (r_state == S_WRITE);
        issue              = (r_state == S_SCAN) && (r_rd_addr != r_count);
        scan_start         = (n_state == S_SCAN) && (r_state != S_SCAN);
        emit               = (r_state == S_EMIT) && out_free;
        ram_we             = load_we || emit;
        scan_ctrl.start    = scan_start;
        scan_ctrl.cmp_en   = r_pend;
        scan_ctrl.cand_ok  = !ram_rdata.done;
        scan_ctrl.any_imag = r_any_imag;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_any_imag  <= 1'b0;
            r_rd_addr   <= '0;
            r_pend      <= 1'b0;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;

            // store write closes the load of one item
            if (load_we) begin
                r_count    <= r_count + CW'(1);
                r_any_imag <= r_any_imag | (r_in.imag_part != '0);
            end

            // scan address counter
            if (scan_start) begin
                r_rd_addr <= '0;
            end else if (issue) begin
                r_rd_addr <= r_rd_addr + CW'(1);
            end

            // result register
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // emit count; the set empties after its final result
            if (emit) begin
                if (last_emit) begin
                    r_emit_cnt  <= '0;
                    r_count     <= '0;
                    r_any_imag  <= 1'b0;
                end else begin
                    r_emit_cnt  <= r_emit_cnt + CW'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in.data;
        end
        r_pend_addr <= r_rd_addr[AW-1:0];
        if (emit) begin
            r_out.sorted_real <= best.re;
            r_out.sorted_imag <= best.im;
            r_out.sorted_tag  <= best.tag;
            r_out.last_out    <= last_emit;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // store entry: a new item on load, the emitted entry marked done on emit
    always_comb begin
        if (load_we) begin
            ram_waddr        = r_count[AW-1:0];
            ram_wdata.sq_mag = sq_mag;
            ram_wdata.re     = r_in.real_part;
            ram_wdata.im     = r_in.imag_part;
            ram_wdata.tag    = r_in.tag;
            ram_wdata.done   = 1'b0;
        end else begin
            ram_waddr        = best_addr;
            ram_wdata        = best;
            ram_wdata.done   = 1'b1;
        end
    end

    cdts_sqmag u_sqmag (
        .i_clk    (i_clk),
        .i_ctrl   (sq_ctrl),
        .i_re     (r_in.real_part),
        .i_im     (r_in.imag_part),
        .o_sq_mag (sq_mag)
    );

    cdts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (1 << AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    cdts_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (scan_ctrl),
        .i_entry     (ram_rdata),
        .i_addr      (r_pend_addr),
        .o_best      (best),
        .o_best_addr (best_addr)
    );

endmodule

// ----- rtl/cdts_checker.sv -----
// ----------------------------------------------------------------------------
// cdts_checker
// Port-level checks for the complex descending tagged sort, bound to the top.
// ----------------------------------------------------------------------------
`include "complex_descending_tagged_sort_macros.svh"

module cdts_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  cdts_pkg::t_out_item i_out_data
);
    import cdts_pkg::*;

    logic out_stall;
    logic out_final;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_final = i_out_valid && i_out_ready && i_out_data.last_out;

    // a stalled result stays offered
    `CDTS_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, out_stall, i_out_valid)
    // and keeps its payload
    `CDTS_ASSERT_HOLD(a_out_data_hold, i_clk, i_rst_n, out_stall, i_out_data)
    // valid drops after the final result is taken
    `CDTS_ASSERT_NEXT(a_final_drains, i_clk, i_rst_n, out_final, !i_out_valid)

endmodule

bind complex_descending_tagged_sort cdts_checker u_cdts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ----- verif/complex_descending_tagged_sort_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_descending_tagged_sort_tb
// Loads sets of tagged complex values and checks that each set comes back in
// descending order: real part when every stored imaginary part is zero, else
// squared magnitude, with ties in load order. It runs a directed table first,
// then random sets that include full and overflowing sets. A long output
// hold-off and drain pauses are part of the run.
// ----------------------------------------------------------------------------
module complex_descending_tagged_sort_tb;
    import cdts_pkg::*;

    localparam int MAX_ITEMS    = 64;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_PCT     = 38;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 500000;

    // one directed row; the expected fields are used only when typed is set
    typedef struct packed {
        logic [WORD_W-1:0] re;
        logic [WORD_W-1:0] im;
        logic [TAG_W-1:0]  tag;
        logic              last;
        logic              typed;
        logic [WORD_W-1:0] exp_re;
        logic [WORD_W-1:0] exp_im;
        logic [TAG_W-1:0]  exp_tag;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    cdts_stream_if #(.t_data(t_in_item))  in_ch ();
    cdts_stream_if #(.t_data(t_out_item)) out_ch ();

    complex_descending_tagged_sort #(
        .MAX_ITEMS (MAX_ITEMS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow of the stored set
    logic [WORD_W-1:0] held_real [MAX_ITEMS];
    logic [WORD_W-1:0] held_imag [MAX_ITEMS];
    logic [TAG_W-1:0]  held_tag  [MAX_ITEMS];
    int                held_count = 0;
    bit                held_any_imag = 1'b0;

    t_out_item ranked_batch [$];
    t_out_item expected_sorted [$];

    int fail_count  = 0;
    int cycle_count = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;

    t_stim_row directed_rows [17];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // squared magnitude of a stored entry, exact in 64 unsigned bits
    function automatic logic [63:0] mag_sq(input int idx);
        longint      sr;
        longint      si;
        logic [63:0] ar;
        logic [63:0] ai;
        sr = longint'($signed(held_real[idx]));
        si = longint'($signed(held_imag[idx]));
        ar = (sr < 0) ? 64'(-sr) : 64'(sr);
        ai = (si < 0) ? 64'(-si) : 64'(si);
        return ar * ar + ai * ai;
    endfunction

    // slot a goes strictly ahead of slot b
    function automatic bit outranks(input int a, input int b);
        if (held_any_imag)
            return mag_sq(a) > mag_sq(b);
        return $signed(held_real[a]) > $signed(held_real[b]);
    endfunction

    // store one value; on the closing item fill ranked_batch with the sorted set
    function automatic void load_and_rank(input t_in_item item);
        int        order [MAX_ITEMS];
        int        i;
        int        j;
        t_out_item res;
        ranked_batch.delete();
        if (held_count < MAX_ITEMS) begin
            held_real[held_count] = item.real_part;
            held_imag[held_count] = item.imag_part;
            held_tag[held_count]  = item.tag;
            if (item.imag_part != '0)
                held_any_imag = 1'b1;
            held_count++;
        end
        if (!item.last_in)
            return;
        // stable insertion sort, descending
        for (i = 0; i < held_count; i++) begin
            j = i;
            while (j > 0 && outranks(i, order[j-1])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i < held_count; i++) begin
            res.sorted_real = held_real[order[i]];
            res.sorted_imag = held_imag[order[i]];
            res.sorted_tag  = held_tag[order[i]];
            res.last_out    = (i == held_count - 1);
            ranked_batch.push_back(res);
        end
        held_count    = 0;
        held_any_imag = 1'b0;
    endfunction

    // random word biased toward extremes and small values (ties)
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(0, 6)) - 32'd3;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic offer_item(input t_in_item item, input bit typed,
                              input t_out_item typed_result);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        load_and_rank(item);
        if (typed)
            expected_sorted.push_back(typed_result);
        else
            foreach (ranked_batch[k])
                expected_sorted.push_back(ranked_batch[k]);
        @(negedge i_clk);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_sorted.size() != 0)
            @(negedge i_clk);
    endtask

    // output ready: random idling, long hold-off on request, none while quiet
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (quiet) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_sorted.size() == 0) begin
                fail_count++;
                $display("%0t: result with nothing expected: expected none, got %h %h %h %b",
                         $time, got.sorted_real, got.sorted_imag, got.sorted_tag,
                         got.last_out);
            end else begin
                want = expected_sorted.pop_front();
                if (got.sorted_real !== want.sorted_real) begin
                    fail_count++;
                    $display("%0t: sorted_real expected %h got %h",
                             $time, want.sorted_real, got.sorted_real);
                end
                if (got.sorted_imag !== want.sorted_imag) begin
                    fail_count++;
                    $display("%0t: sorted_imag expected %h got %h",
                             $time, want.sorted_imag, got.sorted_imag);
                end
                if (got.sorted_tag !== want.sorted_tag) begin
                    fail_count++;
                    $display("%0t: sorted_tag expected %h got %h",
                             $time, want.sorted_tag, got.sorted_tag);
                end
                if (got.last_out !== want.last_out) begin
                    fail_count++;
                    $display("%0t: last_out expected %b got %b",
                             $time, want.last_out, got.last_out);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_in_item item;
        int       r;
        int       k;
        int       set_idx;
        int       set_len;
        int       items_sent;
        bit       real_only;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        directed_rows = '{
            // single-item sets right after reset: value comes straight back
            '{32'h7FFF_FFFF, 32'h0000_0000, 10'h3FF, 1'b1, 1'b1,
              32'h7FFF_FFFF, 32'h0000_0000, 10'h3FF},
            '{32'h8000_0000, 32'h8000_0000, 10'h000, 1'b1, 1'b1,
              32'h8000_0000, 32'h8000_0000, 10'h000},
            '{32'h0000_0000, 32'h0000_0001, 10'h155, 1'b1, 1'b1,
              32'h0000_0000, 32'h0000_0001, 10'h155},
            // real-only set: signed order, extremes, a tie on zero
            '{32'h0000_0000, 32'h0, 10'h001, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h7FFF_FFFF, 32'h0, 10'h002, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h8000_0000, 32'h0, 10'h003, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h0000_0000, 32'h0, 10'h004, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'hFFFF_FFFF, 32'h0, 10'h005, 1'b1, 1'b0, 32'h0, 32'h0, 10'h0},
            // complex set: three values of equal modulus keep load order
            '{32'hFFFD_0000, 32'h0004_0000, 10'h006, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h0005_0000, 32'h0000_0000, 10'h007, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h0000_0000, 32'hFFFB_0000, 10'h008, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h0001_0000, 32'h0001_0000, 10'h009, 1'b1, 1'b0, 32'h0, 32'h0, 10'h0},
            // largest magnitudes, sum up to 2^63
            '{32'h8000_0000, 32'h8000_0000, 10'h00A, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 10'h00B, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 10'h00C, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h8000_0000, 32'h0000_0000, 10'h00D, 1'b0, 1'b0, 32'h0, 32'h0, 10'h0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'h00E, 1'b1, 1'b0, 32'h0, 32'h0, 10'h0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (r = 0; r < $size(directed_rows); r++) begin
            item = '{directed_rows[r].re, directed_rows[r].im,
                     directed_rows[r].tag, directed_rows[r].last};
            offer_item(item, directed_rows[r].typed,
                       '{directed_rows[r].exp_re, directed_rows[r].exp_im,
                         directed_rows[r].exp_tag, 1'b1});
        end

        // random sets; one full set and one that overflows the store
        set_idx    = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (set_idx == 4)
                set_len = MAX_ITEMS;
            else if (set_idx == 9)
                set_len = MAX_ITEMS + 3;
            else if (set_idx == 2)
                set_len = 8;
            else
                set_len = $urandom_range(1, 10);
            // overflow set: stored part real-only, dropped items carry imag
            real_only = ($urandom_range(0, 2) == 0) || (set_idx == 9);
            quiet     = (items_sent >= 180 && items_sent < 280);
            if (set_idx == 2)
                hold_req = 1'b1;
            if (set_idx == 6 || set_idx == 12)
                drain_outputs();
            for (k = 0; k < set_len; k++) begin
                item.real_part = pick_word();
                item.imag_part = (real_only && k < MAX_ITEMS) ? '0 : pick_word();
                item.tag       = TAG_W'($urandom_range(0, 1023));
                item.last_in   = (k == set_len - 1);
                offer_item(item, 1'b0, '0);
            end
            items_sent += set_len;
            set_idx++;
        end

        // wrap up
        quiet = 1'b0;
        drain_outputs();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
